// ===== rtl/swld_pkg.sv =====
// swld_pkg: shared types and constants for the square-wave lock-in detector
// no dependencies; imported by every module under rtl/
package swld_pkg;

   localparam int HALF_BITS  = 8;
   localparam int WIN_BITS   = 16;
   localparam int SHIFT_BITS = 4;
   localparam int SUM_BITS   = 27;
   localparam int LEVEL_BITS = 26;
   localparam int DET_BITS   = 27;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_PERIOD    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECIMATION_LEN = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESULT_SHIFT   = 2'd2;

   localparam logic [HALF_BITS-1:0]  HALF_PERIOD_RESET    = 8'd16;
   localparam logic [WIN_BITS-1:0]   DECIMATION_LEN_RESET = 16'd4096;
   localparam logic [SHIFT_BITS-1:0] RESULT_SHIFT_RESET   = 4'd5;

   // accumulator stage to output stage
   typedef struct packed {
      logic                drive_on;
      logic                result_valid;
      logic [SUM_BITS-1:0] on_sum;
      logic [SUM_BITS-1:0] off_sum;
   } accum_result_type;

endpackage

// ===== rtl/swld_accum.sv =====
// swld_accum: drive phase counter, window counter and the two running sums
// depends on swld_pkg; registers one accum_result_type per accepted sample
module swld_accum #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [SAMPLE_BITS-1:0]           sample,
   input  logic [swld_pkg::HALF_BITS-1:0]   half_period,
   input  logic [swld_pkg::WIN_BITS-1:0]    decimation_len,
   output logic                             out_valid,
   input  logic                             out_ready,
   output swld_pkg::accum_result_type       out_data
);
   import swld_pkg::*;

   logic [WIN_BITS-1:0]  window_count_ff, window_count_in;
   logic [HALF_BITS-1:0] phase_count_ff, phase_count_in;
   logic                 drive_ff, drive_in;
   logic [SUM_BITS-1:0]  on_sum_ff, on_sum_in;
   logic [SUM_BITS-1:0]  off_sum_ff, off_sum_in;
   logic                 valid_ff, valid_in;
   accum_result_type     data_ff, data_in;

   logic [WIN_BITS-1:0]  window_inc;
   logic [HALF_BITS-1:0] phase_inc, phase_mid;
   logic [SUM_BITS-1:0]  sample_ext, on_add, off_add;
   logic                 window_done, toggle, advance;

   assign in_ready = !valid_ff || out_ready;
   assign advance  = in_valid && in_ready;

   always_comb begin
      sample_ext  = {{(SUM_BITS-SAMPLE_BITS){1'b0}}, sample};
      window_inc  = window_count_ff + 1'b1;
      phase_inc   = phase_count_ff + 1'b1;
      on_add      = drive_ff ? on_sum_ff + sample_ext : on_sum_ff;
      off_add     = drive_ff ? off_sum_ff : off_sum_ff + sample_ext;
      window_done = (window_inc == decimation_len);

      // end of window clears the sums and forces a drive toggle
      if (window_done) begin
         on_sum_in       = '0;
         off_sum_in      = '0;
         window_count_in = '0;
         phase_mid       = half_period;
      end else begin
         on_sum_in       = on_add;
         off_sum_in      = off_add;
         window_count_in = window_inc;
         phase_mid       = phase_inc;
      end

      toggle         = (phase_mid == half_period);
      drive_in       = drive_ff ^ toggle;
      phase_count_in = toggle ? '0 : phase_mid;

      data_in.drive_on     = drive_in;
      data_in.result_valid = window_done;
      data_in.on_sum       = on_add;
      data_in.off_sum      = off_add;

      valid_in = advance ? 1'b1 : (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_count_ff <= '0;
         phase_count_ff  <= '0;
         drive_ff        <= 1'b0;
         on_sum_ff       <= '0;
         off_sum_ff      <= '0;
         valid_ff        <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (advance) begin
            window_count_ff <= window_count_in;
            phase_count_ff  <= phase_count_in;
            drive_ff        <= drive_in;
            on_sum_ff       <= on_sum_in;
            off_sum_ff      <= off_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/swld_format.sv =====
// swld_format: scales both sums, forms the signed difference, holds the result
// depends on swld_pkg; fed by swld_accum
module swld_format (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  swld_pkg::accum_result_type       in_data,
   input  logic [swld_pkg::SHIFT_BITS-1:0]  result_shift,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic                             drive_on,
   output logic                             result_valid,
   output logic [swld_pkg::LEVEL_BITS-1:0]  excited_level,
   output logic [swld_pkg::LEVEL_BITS-1:0]  ambient_level,
   output logic signed [swld_pkg::DET_BITS-1:0] detection
);
   import swld_pkg::*;

   logic                        valid_ff, valid_in;
   logic                        drive_ff;
   logic                        result_ff;
   logic [LEVEL_BITS-1:0]       excited_ff, excited_in;
   logic [LEVEL_BITS-1:0]       ambient_ff, ambient_in;
   logic signed [DET_BITS-1:0]  det_ff, det_in;
   logic [SUM_BITS-1:0]         on_shifted, off_shifted;
   logic                        advance;

   assign in_ready = !valid_ff || out_ready;
   assign advance  = in_valid && in_ready;

   always_comb begin
      on_shifted  = in_data.on_sum >> result_shift;
      off_shifted = in_data.off_sum >> result_shift;
      // levels and detection read zero on samples that close no window
      if (in_data.result_valid) begin
         excited_in = on_shifted[LEVEL_BITS-1:0];
         ambient_in = off_shifted[LEVEL_BITS-1:0];
      end else begin
         excited_in = '0;
         ambient_in = '0;
      end
      det_in   = $signed({{(DET_BITS-LEVEL_BITS){1'b0}}, excited_in})
               - $signed({{(DET_BITS-LEVEL_BITS){1'b0}}, ambient_in});
      valid_in = advance ? 1'b1 : (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         drive_ff   <= in_data.drive_on;
         result_ff  <= in_data.result_valid;
         excited_ff <= excited_in;
         ambient_ff <= ambient_in;
         det_ff     <= det_in;
      end
   end

   assign out_valid     = valid_ff;
   assign drive_on      = drive_ff;
   assign result_valid  = result_ff;
   assign excited_level = excited_ff;
   assign ambient_level = ambient_ff;
   assign detection     = det_ff;

endmodule

// ===== rtl/square_wave_lockin_detector.sv =====
// square_wave_lockin_detector: top level, configuration registers and two stages
// depends on swld_pkg, swld_accum, swld_format
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_adc_sample
//   rsp      out        rsp_valid / rsp_ready  drive_on, result_valid, levels, detection
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// one sample per cycle sustained while rsp is not stalled; each result passes through
// the accumulator register, then the scaling/difference register.
// reset is synchronous: counters, sums and drive clear, registers take defaults.
// a stall on rsp backs up through both stages; req_ready drops only when both are full.
// csr writes are always taken; unknown indexes are dropped.
module square_wave_lockin_detector #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [SAMPLE_BITS-1:0]               req_adc_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_drive_on,
   output logic                                 rsp_result_valid,
   output logic [swld_pkg::LEVEL_BITS-1:0]      rsp_excited_level,
   output logic [swld_pkg::LEVEL_BITS-1:0]      rsp_ambient_level,
   output logic signed [swld_pkg::DET_BITS-1:0] rsp_detection,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [swld_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [swld_pkg::WIN_BITS-1:0]        csr_data
);
   import swld_pkg::*;

   logic [HALF_BITS-1:0]  half_period_ff;
   logic [WIN_BITS-1:0]   decimation_len_ff;
   logic [SHIFT_BITS-1:0] result_shift_ff;

   logic             mid_valid, mid_ready;
   accum_result_type mid_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff    <= HALF_PERIOD_RESET;
         decimation_len_ff <= DECIMATION_LEN_RESET;
         result_shift_ff   <= RESULT_SHIFT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HALF_PERIOD:    half_period_ff    <= csr_data[HALF_BITS-1:0];
            CSR_DECIMATION_LEN: decimation_len_ff <= csr_data;
            CSR_RESULT_SHIFT:   result_shift_ff   <= csr_data[SHIFT_BITS-1:0];
            default: ;
         endcase
      end
   end

   swld_accum #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_accum (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .sample         (req_adc_sample),
      .half_period    (half_period_ff),
      .decimation_len (decimation_len_ff),
      .out_valid      (mid_valid),
      .out_ready      (mid_ready),
      .out_data       (mid_data)
   );

   swld_format u_format (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (mid_valid),
      .in_ready      (mid_ready),
      .in_data       (mid_data),
      .result_shift  (result_shift_ff),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .drive_on      (rsp_drive_on),
      .result_valid  (rsp_result_valid),
      .excited_level (rsp_excited_level),
      .ambient_level (rsp_ambient_level),
      .detection     (rsp_detection)
   );

endmodule

// ===== test/tb_square_wave_lockin_detector.sv =====
// tb_square_wave_lockin_detector: self-checking bench for the lock-in detector
// predicts drive level, window sums and detection for each sample; needs swld_pkg
`timescale 1ns / 1ps

module tb_square_wave_lockin_detector;
   import swld_pkg::*;

   localparam int SAMPLE_W = 10;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'h3FF;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int HOLD_CYCLES = 60;
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic                  drive_on;
      logic                  result_valid;
      logic [LEVEL_BITS-1:0] excited_level;
      logic [LEVEL_BITS-1:0] ambient_level;
      logic [DET_BITS-1:0]   detection;
   } lockin_report_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [SAMPLE_W-1:0]           req_adc_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_drive_on;
   logic                          rsp_result_valid;
   logic [LEVEL_BITS-1:0]         rsp_excited_level;
   logic [LEVEL_BITS-1:0]         rsp_ambient_level;
   logic signed [DET_BITS-1:0]    rsp_detection;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [WIN_BITS-1:0]           csr_data = '0;

   // predictor copy of registers and state
   logic [HALF_BITS-1:0]  cfg_half;
   logic [WIN_BITS-1:0]   cfg_decim;
   logic [SHIFT_BITS-1:0] cfg_shift;
   logic [WIN_BITS-1:0]   pred_win;
   logic [HALF_BITS-1:0]  pred_phase;
   logic                  pred_drive;
   logic [SUM_BITS-1:0]   on_acc;
   logic [SUM_BITS-1:0]   off_acc;

   lockin_report_type pending_reports[$];

   int error_count = 0;
   int samples_sent = 0;
   int windows_closed = 0;
   int reg_writes = 0;
   int burst_left = 0;
   int gap_max = 0;
   int stall_pct = 0;
   int hold_left = 0;
   logic hold_req = 1'b0;

   square_wave_lockin_detector #(.SAMPLE_BITS(SAMPLE_W)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_adc_sample(req_adc_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_drive_on(rsp_drive_on),
      .rsp_result_valid(rsp_result_valid),
      .rsp_excited_level(rsp_excited_level),
      .rsp_ambient_level(rsp_ambient_level),
      .rsp_detection(rsp_detection),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic reset_predictor();
      cfg_half   = HALF_PERIOD_RESET;
      cfg_decim  = DECIMATION_LEN_RESET;
      cfg_shift  = RESULT_SHIFT_RESET;
      pred_win   = '0;
      pred_phase = '0;
      pred_drive = 1'b0;
      on_acc     = '0;
      off_acc    = '0;
   endtask

   function automatic lockin_report_type lockin_predict(input logic [SAMPLE_W-1:0] s);
      lockin_report_type rep;
      logic [SUM_BITS-1:0] on_scaled;
      logic [SUM_BITS-1:0] off_scaled;
      rep = '0;
      pred_win   = pred_win + 1'b1;
      pred_phase = pred_phase + 1'b1;
      if (pred_drive) begin
         on_acc = on_acc + SUM_BITS'(s);
      end else begin
         off_acc = off_acc + SUM_BITS'(s);
      end
      if (pred_win == cfg_decim) begin
         on_scaled  = on_acc >> cfg_shift;
         off_scaled = off_acc >> cfg_shift;
         rep.result_valid  = 1'b1;
         rep.excited_level = on_scaled[LEVEL_BITS-1:0];
         rep.ambient_level = off_scaled[LEVEL_BITS-1:0];
         rep.detection     = {1'b0, rep.excited_level} - {1'b0, rep.ambient_level};
         on_acc     = '0;
         off_acc    = '0;
         pred_win   = '0;
         pred_phase = cfg_half;
         windows_closed++;
      end
      // window close forces a toggle through the phase match
      if (pred_phase == cfg_half) begin
         pred_drive = ~pred_drive;
         pred_phase = '0;
      end
      rep.drive_on = pred_drive;
      return rep;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0: return '0;
         1: return SAMPLE_MAX;
         default: return SAMPLE_W'($urandom_range(1023));
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [WIN_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_HALF_PERIOD:    cfg_half  = val[HALF_BITS-1:0];
         CSR_DECIMATION_LEN: cfg_decim = val;
         CSR_RESULT_SHIFT:   cfg_shift = val[SHIFT_BITS-1:0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gap_max > 0) begin
            gap = $urandom_range(1, gap_max);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_adc_sample <= s;
      do @(posedge clock); while (!req_ready);
      pending_reports.push_back(lockin_predict(s));
      samples_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic feed_until_window(input int max_pct);
      int target;
      target = windows_closed + 1;
      while (windows_closed < target) begin
         send_sample(($urandom_range(99) < max_pct) ? SAMPLE_MAX : pick_sample());
      end
   endtask

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // receiver: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      lockin_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("rsp transaction with nothing expected");
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("drive_on", 32'(want.drive_on), 32'(rsp_drive_on));
            check_field("result_valid", 32'(want.result_valid), 32'(rsp_result_valid));
            check_field("excited_level", 32'(want.excited_level), 32'(rsp_excited_level));
            check_field("ambient_level", 32'(want.ambient_level), 32'(rsp_ambient_level));
            check_field("detection", 32'($signed(want.detection)), 32'(rsp_detection));
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("tb_square_wave_lockin_detector: done, errors");
      $finish;
   end

   // reset defaults: no window yet, drive toggles after 16 samples
   task automatic test_reset_defaults();
      gap_max   = 0;
      stall_pct = 0;
      send_sample(SAMPLE_MAX);
      send_sample('0);
      repeat (15) send_sample(pick_sample());
      drain_results();
   endtask

   task automatic test_window_corners();
      gap_max   = 2;
      stall_pct = 30;
      write_reg(CSR_HALF_PERIOD, 16'hA502);   // upper bits dropped
      write_reg(CSR_RESULT_SHIFT, '0);
      write_reg(CSR_DECIMATION_LEN, pred_win + 16'd2);
      write_reg(CSR_UNUSED_INDEX, 16'hFFFF);  // nothing behind this index
      send_sample(SAMPLE_MAX);
      send_sample('0);
      drain_results();
      // two windows with the same drive pattern: detection of both signs
      write_reg(CSR_DECIMATION_LEN, 16'd4);
      repeat (2) send_sample(SAMPLE_MAX);
      repeat (4) send_sample('0);
      repeat (2) send_sample(SAMPLE_MAX);
      drain_results();
      write_reg(CSR_DECIMATION_LEN, 16'd1);
      repeat (2) send_sample(SAMPLE_MAX);
      drain_results();
   endtask

   task automatic test_random_settings();
      logic [HALF_BITS-1:0]  half;
      logic [SHIFT_BITS-1:0] shift;
      int span;
      for (int p = 0; p < 12; p++) begin
         drain_results();
         case ($urandom_range(4))
            0: half = '0;
            1: half = 8'd1;
            2: half = 8'hFF;
            default: half = HALF_BITS'($urandom_range(2, 24));
         endcase
         case ($urandom_range(3))
            0: shift = '0;
            1: shift = 4'hF;
            default: shift = SHIFT_BITS'($urandom_range(1, 14));
         endcase
         // keep the new length above the running count so windows keep closing
         span = (p % 4 == 3) ? $urandom_range(40, 200) : $urandom_range(1, 24);
         write_reg(CSR_HALF_PERIOD, {8'($urandom), half});
         write_reg(CSR_DECIMATION_LEN, pred_win + WIN_BITS'(span));
         write_reg(CSR_RESULT_SHIFT, {12'($urandom), shift});
         gap_max   = (p % 3 == 0) ? 0 : $urandom_range(1, 6);
         stall_pct = (p % 3 == 1) ? 0 : $urandom_range(10, 70);
         repeat (62) send_sample(pick_sample());
      end
      drain_results();
   endtask

   // receiver holds off while samples keep coming, so req_ready must drop
   task automatic test_backpressure();
      drain_results();
      write_reg(CSR_DECIMATION_LEN, pred_win + 16'd5);
      gap_max   = 0;
      stall_pct = 0;
      hold_req  = 1'b1;
      repeat (24) send_sample(pick_sample());
      drain_results();
   endtask

   // one-sample window, then the top length, closed early by lowering it
   task automatic test_full_length_window();
      gap_max   = 0;
      stall_pct = 5;
      write_reg(CSR_DECIMATION_LEN, pred_win + 16'd1);
      feed_until_window(0);
      drain_results();
      write_reg(CSR_HALF_PERIOD, 16'h00FF);
      write_reg(CSR_RESULT_SHIFT, '0);
      write_reg(CSR_DECIMATION_LEN, 16'hFFFF);
      repeat (20) send_sample(SAMPLE_MAX);
      drain_results();
      write_reg(CSR_DECIMATION_LEN, pred_win + 16'd1);
      feed_until_window(90);
      drain_results();
   endtask

   // length lowered below the running count and to zero: no window closes until raised
   task automatic test_zero_length_window();
      gap_max   = 0;
      stall_pct = 5;
      write_reg(CSR_HALF_PERIOD, '0);
      write_reg(CSR_RESULT_SHIFT, 16'h000F);
      write_reg(CSR_DECIMATION_LEN, 16'd200);
      repeat (100) send_sample(pick_sample());
      drain_results();
      write_reg(CSR_DECIMATION_LEN, '0);
      repeat (20) send_sample(pick_sample());
      drain_results();
      write_reg(CSR_DECIMATION_LEN, pred_win + 16'd1);
      feed_until_window(90);
      drain_results();
   endtask

   initial begin
      reset_predictor();
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_window_corners();
      test_random_settings();
      test_backpressure();
      test_full_length_window();
      test_zero_length_window();
      drain_results();
      repeat (10) @(negedge clock);
      $display("run covered %0d samples, %0d closed windows, %0d register writes", samples_sent,
               windows_closed, reg_writes);
      $display("including one-sample windows, lengths lowered under the count and a long stall");
      if (error_count == 0) begin
         $display("tb_square_wave_lockin_detector: done, clean");
      end else begin
         $display("tb_square_wave_lockin_detector: done, errors");
      end
      $finish;
   end

endmodule
